FILE: rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

    // screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // internal widths
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int IDX_W = $clog2(CELL_COUNT);
    localparam int PTR_W = $clog2(CELL_COUNT + 1);

    // field widths
    localparam int MODE_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int ADDR_IN_W = 11;
    localparam int CELL_W    = 16;
    localparam int OUT_COL_W = 7;
    localparam int OUT_ROW_W = 5;
    localparam int ATTR_W    = 8;

    // command codes
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // character codes
    localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR   = 8'h0A;
    localparam logic [CHAR_W-1:0] BACKSPACE_CHAR = 8'h08;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_SCROLL,
        ST_FILL
    } tcw_state_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [CELL_W-1:0] data;
    } tcw_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } tcw_rd_t;

endpackage

FILE: rtl/core/tcw_ifs.sv
`timescale 1ns / 1ps

// command channel
interface tcw_cmd_if;
    import tcw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [CHAR_W-1:0]    char_code;
    logic [ADDR_IN_W-1:0] cell_address;

    modport source (output valid, output mode, output char_code, output cell_address,
                    input ready);
    modport sink   (input valid, input mode, input char_code, input cell_address,
                    output ready);
endinterface

// response channel
interface tcw_rsp_if;
    import tcw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CELL_W-1:0]    cell_value;
    logic [OUT_COL_W-1:0] cursor_column;
    logic [OUT_ROW_W-1:0] cursor_row;
    logic                 scrolled;

    modport source (output valid, output cell_value, output cursor_column,
                    output cursor_row, output scrolled, input ready);
    modport sink   (input valid, input cell_value, input cursor_column,
                    input cursor_row, input scrolled, output ready);
endinterface

// attribute write channel
interface tcw_cfg_if;
    import tcw_pkg::*;
    logic              valid;
    logic              ready;
    logic [ATTR_W-1:0] text_attribute;

    modport source (output valid, output text_attribute, input ready);
    modport sink   (input valid, input text_attribute, output ready);
endinterface

FILE: rtl/core/text_console_writer_core.sv
`timescale 1ns / 1ps

// text console writer: keeps an 80x25 screen of 16-bit cells (attribute in the
// high byte, character in the low byte) in one synchronous ram, plus a cursor.
// each command transfer returns exactly one response transfer. writing a
// character, backspace, newline without scroll, a cell read and the unused mode
// are accepted, then answered by loading the response register once it is free.
// clear sweeps every cell, one ram write a cycle. a scroll copies rows 1..ROWS-1
// up one row through the ram's read and write ports, one cell a cycle, then
// blanks the bottom row. a new command is taken while the previous response
// still waits in the output register. the attribute is written through its own
// channel, which is always ready.
module text_console_writer_core (
    input  logic      clk,
    input  logic      rst_n,
    tcw_cfg_if.sink   cfg,
    tcw_cmd_if.sink   cmd,
    tcw_rsp_if.source rsp
);
    import tcw_pkg::*;

    tcw_state_t state_reg, state_next;

    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [ATTR_W-1:0]    attr_reg;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic [IDX_W-1:0]     dst_reg, dst_next;
    logic                 pend_reg, pend_next;
    logic                 rd_sel_reg, rd_sel_next;
    logic                 scrolled_reg, scrolled_next;

    logic                 rsp_valid_reg, rsp_valid_next;
    logic [CELL_W-1:0]    rsp_value_reg, rsp_value_next;
    logic [OUT_COL_W-1:0] rsp_col_reg, rsp_col_next;
    logic [OUT_ROW_W-1:0] rsp_row_reg, rsp_row_next;
    logic                 rsp_scr_reg, rsp_scr_next;

    tcw_wr_t           ram_wr;
    tcw_rd_t           ram_rd;
    logic [CELL_W-1:0] ram_rd_data;

    logic             cmd_fire;
    logic             col_last;
    logic             row_last;
    logic             is_newline;
    logic             is_backspace;
    logic             scroll_need;
    logic             addr_ok;
    logic             slot_free;
    logic [IDX_W-1:0] cur_idx;
    logic [CELL_W-1:0] blank_cell;

    tcw_screen_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (ram_rd_data)
    );

    assign cfg.ready = 1'b1;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.cell_value    = rsp_value_reg;
    assign rsp.cursor_column = rsp_col_reg;
    assign rsp.cursor_row    = rsp_row_reg;
    assign rsp.scrolled      = rsp_scr_reg;

    // cursor decode
    assign col_last     = (col_reg == COL_W'(COLUMNS - 1));
    assign row_last     = (row_reg == ROW_W'(ROWS - 1));
    assign is_newline   = (cmd.char_code == NEWLINE_CHAR);
    assign is_backspace = (cmd.char_code == BACKSPACE_CHAR);
    assign cur_idx      = IDX_W'(row_reg) * IDX_W'(COLUMNS) + IDX_W'(col_reg);
    assign addr_ok      = (32'(cmd.cell_address) < CELL_COUNT);
    assign blank_cell   = {attr_reg, BLANK_CHAR};
    assign slot_free    = !rsp_valid_reg || rsp.ready;

    // a newline or a wrapping character on the bottom row scrolls
    assign scroll_need = (cmd.mode == MODE_WRITE) && row_last &&
                         (is_newline || (!is_backspace && col_last));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.mode == MODE_CLEAR)
                    begin
                        state_next = ST_FILL;
                    end
                    else if (scroll_need)
                    begin
                        state_next = ST_SCROLL;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCROLL:
            begin
                if (ptr_reg == PTR_W'(CELL_COUNT))
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (ptr_reg == PTR_W'(CELL_COUNT - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        ptr_next       = ptr_reg;
        dst_next       = dst_reg;
        pend_next      = pend_reg;
        rd_sel_next    = rd_sel_reg;
        scrolled_next  = scrolled_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_value_next = rsp_value_reg;
        rsp_col_next   = rsp_col_reg;
        rsp_row_next   = rsp_row_reg;
        rsp_scr_next   = rsp_scr_reg;
        ram_wr         = '0;
        ram_rd         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    rd_sel_next   = 1'b0;
                    scrolled_next = 1'b0;
                    pend_next     = 1'b0;
                    // first source cell of a scroll
                    ptr_next      = PTR_W'(COLUMNS);
                    case (cmd.mode)
                        MODE_WRITE:
                        begin
                            if (is_newline)
                            begin
                                col_next      = '0;
                                scrolled_next = row_last;
                                if (!row_last)
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                            else if (is_backspace)
                            begin
                                // nothing happens at column zero
                                if (col_reg != '0)
                                begin
                                    col_next     = col_reg - 1'b1;
                                    ram_wr.en    = 1'b1;
                                    ram_wr.addr  = cur_idx - 1'b1;
                                    ram_wr.data  = blank_cell;
                                end
                            end
                            else
                            begin
                                ram_wr.en   = 1'b1;
                                ram_wr.addr = cur_idx;
                                ram_wr.data = {attr_reg, cmd.char_code};
                                if (col_last)
                                begin
                                    col_next      = '0;
                                    scrolled_next = row_last;
                                    if (!row_last)
                                    begin
                                        row_next = row_reg + 1'b1;
                                    end
                                end
                                else
                                begin
                                    col_next = col_reg + 1'b1;
                                end
                            end
                        end
                        MODE_CLEAR:
                        begin
                            col_next = '0;
                            row_next = '0;
                            ptr_next = '0;
                        end
                        MODE_READ:
                        begin
                            ram_rd.en   = addr_ok;
                            ram_rd.addr = IDX_W'(cmd.cell_address);
                            rd_sel_next = addr_ok;
                        end
                        default:
                        begin
                            // unused mode leaves the cursor and the screen alone
                            rd_sel_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCROLL:
            begin
                // write back the cell read in the previous cycle, one row higher
                ram_wr.en   = pend_reg;
                ram_wr.addr = dst_reg;
                ram_wr.data = ram_rd_data;
                if (ptr_reg != PTR_W'(CELL_COUNT))
                begin
                    ram_rd.en   = 1'b1;
                    ram_rd.addr = ptr_reg[IDX_W-1:0];
                    dst_next    = IDX_W'(ptr_reg - PTR_W'(COLUMNS));
                    ptr_next    = ptr_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    ptr_next  = PTR_W'((ROWS - 1) * COLUMNS);
                end
            end
            ST_FILL:
            begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = ptr_reg[IDX_W-1:0];
                ram_wr.data = blank_cell;
                ptr_next    = ptr_reg + 1'b1;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_value_next = rd_sel_reg ? ram_rd_data : '0;
                    rsp_col_next   = OUT_COL_W'(col_reg);
                    rsp_row_next   = OUT_ROW_W'(row_reg);
                    rsp_scr_next   = scrolled_reg;
                end
            end
            default:
            begin
                ram_wr = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            attr_reg      <= ATTR_RESET;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                attr_reg <= cfg.text_attribute;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        dst_reg       <= dst_next;
        rd_sel_reg    <= rd_sel_next;
        scrolled_reg  <= scrolled_next;
        rsp_value_reg <= rsp_value_next;
        rsp_col_reg   <= rsp_col_next;
        rsp_row_reg   <= rsp_row_next;
        rsp_scr_reg   <= rsp_scr_next;
    end

endmodule

FILE: rtl/core/tcw_screen_ram.sv
`timescale 1ns / 1ps

module tcw_screen_ram (
    input  logic                    clk,
    input  tcw_pkg::tcw_wr_t        wr,
    input  tcw_pkg::tcw_rd_t        rd,
    output logic [tcw_pkg::CELL_W-1:0] rd_data
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [CELL_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule
